### rtl/integer_to_radix_text_assert.svh
// Assertion macros for the integer to radix text block.
`ifndef INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ITRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itrt assertion failed");
`define ITRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itrt assertion failed");
`else
`define ITRT_ASSERT_IMP(lbl, ante, cons)
`define ITRT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/itrt_pkg.sv
// Shared types, constants and functions of the integer to radix text block.
package itrt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int BASE_WIDTH  = 6;
  localparam int CHAR_WIDTH  = 7;
  localparam int DIGIT_WIDTH = 6;
  localparam int BASE_MIN    = 2;
  localparam int BASE_MAX    = 36;
  localparam int DIV_BITS    = 8;
  localparam int DIV_STEPS   = VALUE_WIDTH / DIV_BITS;
  localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int ADDR_W      = $clog2(VALUE_WIDTH);

  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 7'h00;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA = 7'h57; // 'a' - 10

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [BASE_WIDTH-1:0]         base;
  } in_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] character;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic sign_load;
    logic rd_en;
    logic dig_load;
    logic term_load;
  } cmd_t;

  typedef struct packed {
    logic base_ok;
    logic neg;
    logic div_last;
    logic quo_zero;
    logic last_digit;
    logic out_free;
  } sts_t;

  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] dx;
    dx = {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, d};
    if (d < DIGIT_WIDTH'(10)) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_ALPHA + dx;
  endfunction

endpackage

### rtl/itrt_ctrl.sv
// Sequencing state machine of the integer to radix text block.
module itrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  itrt_pkg::sts_t sts,
  output itrt_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIVIDE = 6'b000010,
    ST_SIGN   = 6'b000100,
    ST_READ   = 6'b001000,
    ST_SEND   = 6'b010000,
    ST_TERM   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.base_ok ? ST_DIVIDE : ST_TERM;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last && sts.quo_zero) begin
          state_nxt = sts.neg ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.sign_load = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (sts.out_free) begin
          cmd.dig_load = 1'b1;
          state_nxt    = sts.last_digit ? ST_TERM : ST_READ;
        end
      end
      ST_TERM: begin
        if (sts.out_free) begin
          cmd.term_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/itrt_dp.sv
// Datapath: digit divider, digit store and output register.
`include "integer_to_radix_text_assert.svh"

module itrt_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  itrt_pkg::in_t  in_data,
  input  itrt_pkg::cmd_t cmd,
  output itrt_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_stall,
  output itrt_pkg::out_t out_data
);

  localparam int W  = itrt_pkg::VALUE_WIDTH;
  localparam int BW = itrt_pkg::BASE_WIDTH;
  localparam int DB = itrt_pkg::DIV_BITS;

  logic [W-1:0]                      div_r;
  logic [BW-1:0]                     rem_r;
  logic [BW-1:0]                     base_r;
  logic                              neg_r;
  logic [itrt_pkg::STEP_W-1:0]       step_r;
  logic [itrt_pkg::CNT_W-1:0]        cnt_r;
  logic [itrt_pkg::DIGIT_WIDTH-1:0]  store [W];
  logic [itrt_pkg::DIGIT_WIDTH-1:0]  rd_data_r;
  logic                              out_valid_r;
  itrt_pkg::out_t                    out_data_r;

  logic [W-1:0]  mag;
  logic          in_neg;
  logic [W-1:0]  quo_nxt;
  logic [BW-1:0] rem_nxt;
  logic [DB-1:0] qbits;
  logic          div_last;
  logic [itrt_pkg::CNT_W-1:0] cnt_dec;

  assign in_neg = in_data.value[W-1];
  assign mag    = in_neg ? (~in_data.value + W'(1)) : in_data.value;

  // DB restoring steps per cycle on the narrow remainder
  always_comb begin
    logic [BW:0] rem_w;
    logic [BW:0] t;
    rem_w = {1'b0, rem_r};
    qbits = '0;
    for (int j = 0; j < DB; j++) begin
      t = {rem_w[BW-1:0], div_r[W-1-j]};
      if (t >= {1'b0, base_r}) begin
        qbits[DB-1-j] = 1'b1;
        rem_w         = t - {1'b0, base_r};
      end else begin
        rem_w = t;
      end
    end
    rem_nxt = rem_w[BW-1:0];
  end

  generate
    if (W > DB) begin : g_shift
      assign quo_nxt = {div_r[W-DB-1:0], qbits};
    end else begin : g_noshift
      assign quo_nxt = qbits;
    end
  endgenerate

  assign div_last = (step_r == itrt_pkg::STEP_W'(itrt_pkg::DIV_STEPS - 1));
  assign cnt_dec  = cnt_r - itrt_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      cnt_r  <= '0;
      neg_r  <= 1'b0;
    end else if (cmd.load) begin
      step_r <= '0;
      cnt_r  <= '0;
      neg_r  <= sts.base_ok ? in_neg : 1'b0;
    end else if (cmd.div_step) begin
      step_r <= div_last ? '0 : step_r + itrt_pkg::STEP_W'(1);
      if (div_last) begin
        cnt_r <= cnt_r + itrt_pkg::CNT_W'(1);
      end
    end else if (cmd.dig_load) begin
      cnt_r <= cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_r  <= mag;
      rem_r  <= '0;
      base_r <= in_data.base;
    end else if (cmd.div_step) begin
      div_r <= quo_nxt;
      rem_r <= div_last ? '0 : rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && div_last) begin
      store[cnt_r[itrt_pkg::ADDR_W-1:0]] <= rem_nxt;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store[cnt_dec[itrt_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sign_load || cmd.dig_load || cmd.term_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sign_load) begin
      out_data_r <= '{character: itrt_pkg::CHAR_MINUS, last: 1'b0};
    end else if (cmd.dig_load) begin
      out_data_r <= '{character: itrt_pkg::digit_char(rd_data_r), last: 1'b0};
    end else if (cmd.term_load) begin
      out_data_r <= '{character: itrt_pkg::CHAR_NUL, last: 1'b1};
    end
  end

  assign sts.base_ok    = (in_data.base >= BW'(itrt_pkg::BASE_MIN)) &&
                          (in_data.base <= BW'(itrt_pkg::BASE_MAX));
  assign sts.neg        = neg_r;
  assign sts.div_last   = div_last;
  assign sts.quo_zero   = (quo_nxt == '0);
  assign sts.last_digit = (cnt_r == itrt_pkg::CNT_W'(1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ITRT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= itrt_pkg::CNT_W'(W))
  `ITRT_ASSERT_IMP(a_store_room, cmd.div_step && div_last, cnt_r < itrt_pkg::CNT_W'(W))
  `ITRT_ASSERT_IMP(a_digit_avail, cmd.dig_load || cmd.rd_en, cnt_r != '0)
  `ITRT_ASSERT_IMP(a_rem_below_base, cmd.div_step, rem_r < base_r)
  `ITRT_ASSERT_NXT(a_load_clears, cmd.load, cnt_r == '0 && step_r == '0)

endmodule

### rtl/integer_to_radix_text.sv
// Top level of the integer to radix text block.
//
// in_valid/in_stall/in_data carry one transaction: a signed 32-bit value and
// a 6-bit base. out_valid/out_stall/out_data return the ASCII text of the
// value, one character per transaction, most significant digit first, with
// a leading '-' for negative values and a final zero byte marked by last.
// An invalid base (outside 2 to 36) gives only the zero byte.
// in_stall is high from the accepting edge until the terminator has been
// loaded into the output register; one input is converted at a time.
// The divider produces 8 quotient bits a cycle over 32 bits, one digit per
// pass, and repeats until the quotient is zero. Output then gives the sign,
// each digit with a store read and an output load, and the terminator; the
// next input is taken in the idle state. A stall on the output holds the
// output register and pauses the sequencer in its output states.
// Synchronous active-low reset clears control state; the digit store is not
// cleared and needs no clearing pass.
module integer_to_radix_text (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  itrt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output itrt_pkg::out_t out_data
);

  itrt_pkg::cmd_t cmd;
  itrt_pkg::sts_t sts;

  itrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itrt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### bench/tb.sv
// Self-checking bench for integer_to_radix_text: random and directed conversions.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    HALF_PERIOD    = 4;
  localparam int    HOLD_CYCLES    = 400;
  localparam int    SETTLE_CYCLES  = 250;
  localparam int    QUIET_LIMIT    = 6000;
  localparam int    MAX_REPORTS    = 10;
  localparam string DIGIT_SET      = "0123456789abcdefghijklmnopqrstuvwxyz";

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  itrt_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  itrt_pkg::out_t out_data;

  integer_to_radix_text u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  itrt_pkg::in_t  pending_values[$];
  itrt_pkg::out_t text_expected[$];

  // predictor state
  logic [itrt_pkg::DIGIT_WIDTH-1:0] digit_buf[itrt_pkg::VALUE_WIDTH];
  int unsigned            digit_len = 0;
  bit                     value_neg = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  int mismatches = 0;
  int n_conv     = 0;
  int n_invalid  = 0;
  int n_negative = 0;
  int n_chars    = 0;

  function automatic itrt_pkg::out_t make_char(logic [itrt_pkg::CHAR_WIDTH-1:0] c,
                                               logic is_last);
    itrt_pkg::out_t r;
    r.character = c;
    r.last      = is_last;
    return r;
  endfunction

  // Expected text of one value; digits built least significant first, then read back reversed.
  function automatic void predict_text(itrt_pkg::in_t item);
    longint          sval;
    longint unsigned mag;
    longint unsigned radix;
    byte             c;
    sval = longint'(item.value);
    if (item.base < itrt_pkg::BASE_MIN || item.base > itrt_pkg::BASE_MAX) begin
      digit_len = 0;
      value_neg = 1'b0;
      n_invalid++;
      text_expected.push_back(make_char(itrt_pkg::CHAR_NUL, 1'b1));
      return;
    end
    radix     = 64'(item.base);
    value_neg = (sval < 0);
    mag       = value_neg ? -sval : sval;
    digit_len = 0;
    do begin
      if (digit_len < itrt_pkg::VALUE_WIDTH) begin
        digit_buf[digit_len] = itrt_pkg::DIGIT_WIDTH'(mag % radix);
        digit_len++;
      end
      mag = mag / radix;
    end while (mag != 0);
    if (value_neg) begin
      n_negative++;
      text_expected.push_back(make_char(itrt_pkg::CHAR_MINUS, 1'b0));
    end
    for (int i = int'(digit_len) - 1; i >= 0; i--) begin
      c = DIGIT_SET[digit_buf[i]];
      text_expected.push_back(make_char(c[itrt_pkg::CHAR_WIDTH-1:0], 1'b0));
    end
    text_expected.push_back(make_char(itrt_pkg::CHAR_NUL, 1'b1));
  endfunction

  function automatic void note_mismatch(string what, itrt_pkg::out_t exp_c,
                                        itrt_pkg::out_t got_c);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected char %h last %b, got char %h last %b", $realtime, what,
               exp_c.character, exp_c.last, got_c.character, got_c.last);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_text(in_data);
        n_conv++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_values.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    itrt_pkg::out_t exp_c;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_chars++;
        if (text_expected.size() == 0) begin
          note_mismatch("unexpected character", '0, out_data);
        end else begin
          exp_c = text_expected.pop_front();
          if (out_data.character !== exp_c.character || out_data.last !== exp_c.last) begin
            note_mismatch("text mismatch", exp_c, out_data);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_value(logic signed [itrt_pkg::VALUE_WIDTH-1:0] v, int b);
    itrt_pkg::in_t item;
    item.value = v;
    item.base  = itrt_pkg::BASE_WIDTH'(b);
    pending_values.push_back(item);
  endtask

  task automatic add_random_value();
    logic signed [itrt_pkg::VALUE_WIDTH-1:0] v;
    int                                      b;
    case ($urandom_range(9))
      0, 1: begin
        v = $urandom_range(40);
        if ($urandom_range(1)) v = -v;
      end
      2: begin
        case ($urandom_range(4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = -1;
          3: v = 0;
          default: v = 1;
        endcase
      end
      default: v = $urandom;
    endcase
    case ($urandom_range(19))
      0: b = $urandom_range(1);
      1: b = $urandom_range(itrt_pkg::BASE_MAX + 1, 63);
      2: b = $urandom_range(1) ? itrt_pkg::BASE_MIN : itrt_pkg::BASE_MAX;
      default: b = $urandom_range(itrt_pkg::BASE_MIN, itrt_pkg::BASE_MAX);
    endcase
    add_value(v, b);
  endtask

  // Wait for all queued values to be taken and every character to come back.
  task automatic wait_drained();
    while (pending_values.size() != 0 || in_valid || text_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) add_random_value();
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, zero, invalid bases, sign handling
    add_value(0, 10);
    add_value(32'sh7fff_ffff, 10);
    add_value(32'sh8000_0000, 10);
    add_value(32'sh8000_0000, itrt_pkg::BASE_MIN);
    add_value(32'sh8000_0000, itrt_pkg::BASE_MAX);
    add_value(32'sh7fff_ffff, itrt_pkg::BASE_MIN);
    add_value(-1, itrt_pkg::BASE_MIN);
    add_value(-1, 10);
    add_value(35, itrt_pkg::BASE_MAX);
    add_value(36, itrt_pkg::BASE_MAX);
    add_value(-35, itrt_pkg::BASE_MAX);
    add_value(32'shdead_beef, 16);
    add_value(32'sh7fff_ffff, 16);
    add_value(511, 8);
    add_value(9, 10);
    add_value(0, itrt_pkg::BASE_MIN);
    add_value(0, itrt_pkg::BASE_MAX);
    add_value(123, 0);
    add_value(-123, 1);
    add_value(123, itrt_pkg::BASE_MAX + 1);
    add_value(32'sh8000_0000, 63);
    add_value(-1, 3);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    @(negedge clk);
    hold_req++;
    run_phase(0, 0, 20);

    run_phase(0, 0, 115);
    run_phase(70, 0, 115);
    run_phase(0, 70, 115);
    run_phase(8, 8, 115);

    if (text_expected.size() != 0) begin
      mismatches++;
      $display("%0d characters never arrived", text_expected.size());
    end
    $display("Converted %0d values (%0d negative, %0d with invalid base), %0d characters checked",
             n_conv, n_negative, n_invalid, n_chars);
    $display("Phases: directed, output hold-off, free flow, input gaps, output stalls, mixed");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/itrt_pkg.sv
rtl/itrt_ctrl.sv
rtl/itrt_dp.sv
rtl/integer_to_radix_text.sv
bench/tb.sv
